[hdl/wav_pcm_stream_parser_assert.svh]
// assertion macros for the wav pcm stream parser
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define WPSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle forces a consequence in the next
`define WPSP_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/wpsp_pkg.sv]
package wpsp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RIFF    = 4'd1,
    PH_RSIZE   = 4'd2,
    PH_WAVE    = 4'd3,
    PH_FMT     = 4'd4,
    PH_FSIZE   = 4'd5,
    PH_AFMT    = 4'd6,
    PH_CHAN    = 4'd7,
    PH_RATE    = 4'd8,
    PH_SKIP6   = 4'd9,
    PH_BITS    = 4'd10,
    PH_ID1     = 4'd11,
    PH_JSKIP   = 4'd12,
    PH_ID2     = 4'd13,
    PH_DSIZE   = 4'd14,
    PH_SAMPLES = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_ACCEPT = 2'd2
  } kind_e;

  localparam logic [2:0] ERR_RIFF     = 3'd0;
  localparam logic [2:0] ERR_WAVE     = 3'd1;
  localparam logic [2:0] ERR_FMT      = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
  localparam logic [2:0] ERR_CHANNELS = 3'd4;
  localparam logic [2:0] ERR_RATE     = 3'd5;
  localparam logic [2:0] ERR_BITS     = 3'd6;
  localparam logic [2:0] ERR_DATA     = 3'd7;

  // chunk tags as seen little-endian in the shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_beat_t;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  sample_value;
    logic [15:0]  channel_index;
    logic         last_sample;
    logic [2:0]   error_code;
    logic [30:0]  rate_seen;
    logic [15:0]  channels_seen;
    logic [5:0]   width_seen;
  } result_t;

  // bytes in each header field
  function automatic logic [5:0] phase_len(input phase_e ph);
    logic [5:0] len;
    case (ph)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE: len = 6'd4;
      PH_AFMT, PH_CHAN, PH_BITS:                    len = 6'd2;
      PH_RATE, PH_ID1, PH_ID2, PH_DSIZE:            len = 6'd4;
      PH_SKIP6:                                     len = 6'd6;
      PH_JSKIP:                                     len = 6'd32;
      default:                                      len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

[hdl/wpsp_in_reg.sv]
module wpsp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  wpsp_pkg::in_beat_t beat_i,
  input  logic               adv_i,
  output logic               fire_o,
  output wpsp_pkg::in_beat_t beat_o
);

  logic               valid_q, valid_d;
  wpsp_pkg::in_beat_t beat_q;

  assign ready_o = !valid_q || adv_i;
  assign fire_o  = valid_q && adv_i;
  assign beat_o  = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_i;
    end
  end

endmodule

[hdl/wpsp_core.sv]
module wpsp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_valid_i,
  input  wpsp_pkg::in_beat_t beat_i,
  output logic               res_valid_o,
  output wpsp_pkg::result_t  res_o
);

  wpsp_pkg::phase_e phase_q, phase_d, ph_eff;
  logic [5:0]  cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic [31:0] shift_q, shift_d, shift_eff, shift_new;
  logic [15:0] chan_total_q, chan_total_d;
  logic [5:0]  width_q, width_d;
  logic [30:0] rate_q, rate_d;
  logic [31:0] left_q, left_d, left_dec;
  logic [17:0] fsize_q, fsize_d, fsize_calc;
  logic [15:0] chan_cnt_q, chan_cnt_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  nbytes;
  logic [5:0]  mshift;
  logic [31:0] smask, svalue;
  logic        active, in_samples, field_done, sample_done, frame_end, last_frame;
  logic        hdr_err, hdr_accept, data_empty;
  logic [2:0]  err_code;

  // a start beat restarts the parse with itself as the first byte
  assign ph_eff    = beat_i.start ? wpsp_pkg::PH_RIFF : phase_q;
  assign cnt_eff   = beat_i.start ? 6'd0 : cnt_q;
  assign shift_eff = beat_i.start ? 32'd0 : shift_q;

  assign active     = beat_valid_i && (ph_eff != wpsp_pkg::PH_IDLE);
  assign in_samples = (ph_eff == wpsp_pkg::PH_SAMPLES);
  assign shift_new  = {beat_i.data, shift_eff[31:8]};
  assign cnt_inc    = cnt_eff + 6'd1;
  assign field_done = (cnt_inc >= wpsp_pkg::phase_len(ph_eff));

  assign nbytes      = width_q[5:3];
  assign sample_done = (({1'b0, pos_q} + 3'd1) >= nbytes);
  assign left_dec    = left_q - 32'd1;
  assign frame_end   = (({1'b0, chan_cnt_q} + 17'd1) >= {1'b0, chan_total_q});
  // the frame just closed is the last whole one when fewer than a frame remain
  assign last_frame  = frame_end && (left_dec < {14'd0, fsize_q});

  always_comb begin
    case (nbytes)
      3'd1:    fsize_calc = {2'b00, chan_total_q};
      3'd2:    fsize_calc = {1'b0, chan_total_q, 1'b0};
      3'd3:    fsize_calc = {2'b00, chan_total_q} + {1'b0, chan_total_q, 1'b0};
      3'd4:    fsize_calc = {chan_total_q, 2'b00};
      default: fsize_calc = 18'd0;
    endcase
  end

  assign data_empty = (shift_new < {14'd0, fsize_calc});

  assign mshift = 6'd32 - width_q;
  assign smask  = 32'hFFFF_FFFF << mshift[4:0];
  assign svalue = (shift_new & smask) ^ {(width_q == 6'd8), 31'd0};

  // header field checks
  always_comb begin
    hdr_err    = 1'b0;
    hdr_accept = 1'b0;
    err_code   = wpsp_pkg::ERR_RIFF;
    case (ph_eff)
      wpsp_pkg::PH_RIFF: begin
        hdr_err  = (shift_new != wpsp_pkg::TAG_RIFF);
        err_code = wpsp_pkg::ERR_RIFF;
      end
      wpsp_pkg::PH_WAVE: begin
        hdr_err  = (shift_new != wpsp_pkg::TAG_WAVE);
        err_code = wpsp_pkg::ERR_WAVE;
      end
      wpsp_pkg::PH_FMT: begin
        hdr_err  = (shift_new != wpsp_pkg::TAG_FMT);
        err_code = wpsp_pkg::ERR_FMT;
      end
      wpsp_pkg::PH_AFMT: begin
        hdr_err  = (shift_new[31:16] != 16'd1);
        err_code = wpsp_pkg::ERR_NOT_PCM;
      end
      wpsp_pkg::PH_CHAN: begin
        hdr_err  = (shift_new[31:16] == 16'd0);
        err_code = wpsp_pkg::ERR_CHANNELS;
      end
      wpsp_pkg::PH_RATE: begin
        hdr_err  = shift_new[31];
        err_code = wpsp_pkg::ERR_RATE;
      end
      wpsp_pkg::PH_BITS: begin
        hdr_err  = !((shift_new[31:16] == 16'd8) || (shift_new[31:16] == 16'd16) ||
                     (shift_new[31:16] == 16'd24) || (shift_new[31:16] == 16'd32));
        err_code = wpsp_pkg::ERR_BITS;
      end
      wpsp_pkg::PH_ID1: begin
        hdr_accept = (shift_new == wpsp_pkg::TAG_DATA);
        hdr_err    = !hdr_accept && (shift_new != wpsp_pkg::TAG_JUNK);
        err_code   = wpsp_pkg::ERR_DATA;
      end
      wpsp_pkg::PH_ID2: begin
        hdr_accept = (shift_new == wpsp_pkg::TAG_DATA);
        hdr_err    = !hdr_accept;
        err_code   = wpsp_pkg::ERR_DATA;
      end
      default: begin
        hdr_err = 1'b0;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (active) begin
      phase_d = ph_eff;
      if (in_samples) begin
        if (sample_done && last_frame) begin
          phase_d = wpsp_pkg::PH_IDLE;
        end
      end else if (field_done) begin
        if (hdr_err) begin
          phase_d = wpsp_pkg::PH_IDLE;
        end else if (hdr_accept) begin
          phase_d = wpsp_pkg::PH_DSIZE;
        end else begin
          case (ph_eff)
            wpsp_pkg::PH_RIFF:  phase_d = wpsp_pkg::PH_RSIZE;
            wpsp_pkg::PH_RSIZE: phase_d = wpsp_pkg::PH_WAVE;
            wpsp_pkg::PH_WAVE:  phase_d = wpsp_pkg::PH_FMT;
            wpsp_pkg::PH_FMT:   phase_d = wpsp_pkg::PH_FSIZE;
            wpsp_pkg::PH_FSIZE: phase_d = wpsp_pkg::PH_AFMT;
            wpsp_pkg::PH_AFMT:  phase_d = wpsp_pkg::PH_CHAN;
            wpsp_pkg::PH_CHAN:  phase_d = wpsp_pkg::PH_RATE;
            wpsp_pkg::PH_RATE:  phase_d = wpsp_pkg::PH_SKIP6;
            wpsp_pkg::PH_SKIP6: phase_d = wpsp_pkg::PH_BITS;
            wpsp_pkg::PH_BITS:  phase_d = wpsp_pkg::PH_ID1;
            wpsp_pkg::PH_ID1:   phase_d = wpsp_pkg::PH_JSKIP;
            wpsp_pkg::PH_JSKIP: phase_d = wpsp_pkg::PH_ID2;
            wpsp_pkg::PH_DSIZE: phase_d = data_empty ? wpsp_pkg::PH_IDLE
                                                     : wpsp_pkg::PH_SAMPLES;
            default:            phase_d = wpsp_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  // results and datapath
  always_comb begin
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    chan_total_d = chan_total_q;
    width_d      = width_q;
    rate_d       = rate_q;
    left_d       = left_q;
    fsize_d      = fsize_q;
    chan_cnt_d   = chan_cnt_q;
    pos_d        = pos_q;

    res_valid_o         = 1'b0;
    res_o.kind          = wpsp_pkg::KIND_SAMPLE;
    res_o.sample_value  = 32'd0;
    res_o.channel_index = 16'd0;
    res_o.last_sample   = 1'b0;
    res_o.error_code    = 3'd0;
    res_o.rate_seen     = 31'd0;
    res_o.channels_seen = 16'd0;
    res_o.width_seen    = 6'd0;

    if (active) begin
      shift_d = shift_new;
      cnt_d   = cnt_eff;
      if (in_samples) begin
        left_d = left_dec;
        if (!sample_done) begin
          pos_d = pos_q + 2'd1;
        end else begin
          res_valid_o         = 1'b1;
          res_o.kind          = wpsp_pkg::KIND_SAMPLE;
          res_o.sample_value  = svalue;
          res_o.channel_index = chan_cnt_q;
          res_o.last_sample   = last_frame;
          pos_d               = 2'd0;
          shift_d             = 32'd0;
          chan_cnt_d          = frame_end ? 16'd0 : chan_cnt_q + 16'd1;
        end
      end else begin
        cnt_d = cnt_inc;
        if (field_done) begin
          cnt_d = 6'd0;
          if (hdr_err) begin
            res_valid_o      = 1'b1;
            res_o.kind       = wpsp_pkg::KIND_ERROR;
            res_o.error_code = err_code;
          end else if (hdr_accept) begin
            res_valid_o         = 1'b1;
            res_o.kind          = wpsp_pkg::KIND_ACCEPT;
            res_o.rate_seen     = rate_q;
            res_o.channels_seen = chan_total_q;
            res_o.width_seen    = width_q;
          end else begin
            case (ph_eff)
              wpsp_pkg::PH_CHAN: chan_total_d = shift_new[31:16];
              wpsp_pkg::PH_RATE: rate_d       = shift_new[30:0];
              wpsp_pkg::PH_BITS: width_d      = shift_new[21:16];
              wpsp_pkg::PH_DSIZE: begin
                fsize_d    = fsize_calc;
                left_d     = shift_new;
                pos_d      = 2'd0;
                chan_cnt_d = 16'd0;
                shift_d    = 32'd0;
              end
              default: cnt_d = 6'd0;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wpsp_pkg::PH_IDLE;
      cnt_q        <= 6'd0;
      shift_q      <= 32'd0;
      chan_total_q <= 16'd0;
      width_q      <= 6'd0;
      rate_q       <= 31'd0;
      left_q       <= 32'd0;
      fsize_q      <= 18'd0;
      chan_cnt_q   <= 16'd0;
      pos_q        <= 2'd0;
    end else begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      shift_q      <= shift_d;
      chan_total_q <= chan_total_d;
      width_q      <= width_d;
      rate_q       <= rate_d;
      left_q       <= left_d;
      fsize_q      <= fsize_d;
      chan_cnt_q   <= chan_cnt_d;
      pos_q        <= pos_d;
    end
  end

endmodule

[hdl/wpsp_out_reg.sv]
module wpsp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wpsp_pkg::result_t res_i,
  output logic              adv_o,
  output logic              valid_o,
  input  logic              ready_i,
  output wpsp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  wpsp_pkg::result_t res_q;

  assign adv_o   = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

[hdl/wav_pcm_stream_parser.sv]
// path: an accepted byte passes the input register and the core, and its result is held in the result register
// throughput: one byte per cycle while the output side keeps ready high
// only a full result register that is not taken stops the input side
// reset: control state clears, the parser waits for a start byte
`include "wav_pcm_stream_parser_assert.svh"

module wav_pcm_stream_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  input  logic               start_req_i,
  // result stream out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] sample_value_o,
  output logic [15:0]        channel_index_o,
  output logic               last_sample_o,
  output logic [2:0]         error_code_o,
  output logic [30:0]        rate_seen_o,
  output logic [15:0]        channels_seen_o,
  output logic [5:0]         width_seen_o
);

  wpsp_pkg::in_beat_t in_beat, core_beat;
  wpsp_pkg::result_t  core_res, out_res;
  logic               in_q_valid;
  logic               core_fire;
  logic               core_res_valid;
  logic               adv;

  assign in_beat.data  = byte_in_i;
  assign in_beat.start = start_req_i;

  // input register: holds one beat, refills in the cycle it drains
  wpsp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .beat_i  (in_beat),
    .adv_i   (adv),
    .fire_o  (core_fire),
    .beat_o  (core_beat)
  );

  assign in_q_valid = core_fire || (!in_ready_o);

  // parse core: header phases, sample assembly, frame counting
  wpsp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (core_fire),
    .beat_i       (core_beat),
    .res_valid_o  (core_res_valid),
    .res_o        (core_res)
  );

  // result register: pipeline advances whenever it is empty or being taken
  wpsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_res_valid),
    .res_i       (core_res),
    .adv_o       (adv),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign sample_value_o  = out_res.sample_value;
  assign channel_index_o = out_res.channel_index;
  assign last_sample_o   = out_res.last_sample;
  assign error_code_o    = out_res.error_code;
  assign rate_seen_o     = out_res.rate_seen;
  assign channels_seen_o = out_res.channels_seen;
  assign width_seen_o    = out_res.width_seen;

  // input side only stalls behind an untaken result
  `WPSP_ASSERT(a_stall_cause, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without a blocked result")
  // the last flag belongs to sample beats only
  `WPSP_ASSERT(a_last_is_sample, (out_valid_o && last_sample_o) |-> (kind_o == wpsp_pkg::KIND_SAMPLE), "last flag on a non-sample beat")
  // error beats carry nothing but the code
  `WPSP_ASSERT(a_error_clean, (out_valid_o && kind_o == wpsp_pkg::KIND_ERROR) |-> (sample_value_o == 32'sd0 && rate_seen_o == 31'd0 && channels_seen_o == 16'd0), "error beat with stray fields")
  // a result needs a byte waiting in the input register
  `WPSP_ASSERT_NXT(a_result_needs_byte, !in_q_valid && !out_valid_o, !out_valid_o, "result appeared without a byte")

endmodule
